@@ design/bcd_pkg.sv @@
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants for the button chord debouncer
// Event codes, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int BTN_COUNT  = 3;
  localparam int ENTRY_REGS = 4;

  localparam int TIME_W   = 32;
  localparam int MS_CFG_W = 16;
  localparam int ENTRY_W  = 8;
  localparam int ACTION_W = 5;
  localparam int EVENT_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [BTN_COUNT-1:0] btn_mask_t;
  typedef logic [TIME_W-1:0]    ms_time_t;
  typedef logic [ACTION_W-1:0]  action_t;
  typedef logic [EVENT_W-1:0]   event_t;
  typedef logic [ENTRY_W-1:0]   chord_entry_t;

  // event codes
  localparam event_t EV_NONE  = 3'd0;
  localparam event_t EV_CHORD = 3'd1;
  localparam event_t EV_DOT   = 3'd2;
  localparam event_t EV_DASH  = 3'd3;
  localparam event_t EV_SEND  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BASE = 3'd2;

  localparam logic [MS_CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [MS_CFG_W-1:0] WINDOW_RESET   = 16'd80;

  // one result item
  typedef struct packed {
    action_t chord_action;
    event_t  event_code;
  } result_t;

endpackage

@@ design/button_chord_debouncer.sv @@
// ----------------------------------------------------------------------------
// button_chord_debouncer: three-button debouncer with chord detection
// Debounces dot, dash and send, gathers chords and emits one event per sample.
// ----------------------------------------------------------------------------
// Each sample on the input stream (a millisecond timestamp and the raw levels
// of dot, dash and send) produces exactly one result transaction. A sample is
// taken every cycle while in_tready is high: the whole update (three wrapping
// time compares, the window compare and a first-match search over the chord
// table) is one pass of logic from the state registers to the output stage,
// where the result of a sample is registered in the result register, or in
// the skid register while the output stalls. This two-entry output stage lets
// the input keep flowing while a result waits; in_tready drops only when both
// entries are full. Configuration writes are taken every cycle (cfg_ready is
// always high) and are meant to arrive while the block is idle.
module button_chord_debouncer import bcd_pkg::*; #(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream, tdata: [31:0] now_ms, [34:32] raw_pressed, [39:35] zero
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,
  // result stream, tdata: [2:0] event_code, [7:3] chord_action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // only table entries the search can reach are stored
  localparam int STORED = (TABLE_ENTRIES < ENTRY_REGS) ? TABLE_ENTRIES : ENTRY_REGS;

  // configuration registers
  logic [MS_CFG_W-1:0] debounce_ms_r;
  logic [MS_CFG_W-1:0] window_ms_r;
  chord_entry_t        entry_r [STORED];

  // debounce and chord state
  btn_mask_t raw_seen_r,      raw_seen_nxt;
  btn_mask_t stable_r,        stable_nxt;
  ms_time_t  change_time_r   [BTN_COUNT];
  ms_time_t  change_time_nxt [BTN_COUNT];
  btn_mask_t gathered_r,      gathered_nxt;
  ms_time_t  window_start_r,  window_start_nxt;
  logic      group_done_r,    group_done_nxt;
  action_t   recent_r,        recent_nxt;

  // output stage
  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;

  ms_time_t  now_ms;
  btn_mask_t raw_pressed;
  logic      in_acc;
  logic      out_take;
  result_t   result;

  assign now_ms      = in_tdata[TIME_W-1:0];
  assign raw_pressed = in_tdata[TIME_W +: BTN_COUNT];
  assign in_tready   = !skid_valid_r;
  assign in_acc      = in_tvalid && in_tready;
  assign out_take    = out_valid_r && out_tready;
  assign cfg_ready   = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= DEBOUNCE_RESET;
      window_ms_r   <= WINDOW_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_DEBOUNCE) begin
        debounce_ms_r <= cfg_data;
      end
      if (cfg_index == CFG_WINDOW) begin
        window_ms_r <= cfg_data;
      end
    end
  end

  for (genvar k = 0; k < STORED; k++) begin : g_entry
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        entry_r[k] <= '0;
      end else if (cfg_valid && (cfg_index == CFG_IDX_W'(CFG_ENTRY_BASE + k))) begin
        entry_r[k] <= cfg_data[ENTRY_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // one-pass update for a sample
  // ---------------------------------------------------------------------------
  logic      fresh;
  btn_mask_t held;
  btn_mask_t gm1;
  ms_time_t  ws1;
  logic      gd1;
  ms_time_t  held_for  [BTN_COUNT];
  ms_time_t  window_age;
  action_t   found_act;
  logic      found;

  always_comb begin
    fresh = 1'b0;
    raw_seen_nxt = raw_pressed;
    stable_nxt   = stable_r;
    for (int i = 0; i < BTN_COUNT; i++) begin
      // a raw edge restarts that button's hold timer
      change_time_nxt[i] = (raw_pressed[i] != raw_seen_r[i]) ? now_ms : change_time_r[i];
      held_for[i] = now_ms - change_time_nxt[i];
      if (held_for[i] >= {{(TIME_W-MS_CFG_W){1'b0}}, debounce_ms_r}) begin
        stable_nxt[i] = raw_pressed[i];
        if (raw_pressed[i] && !stable_r[i]) begin
          fresh = 1'b1;
        end
      end
    end
    held = stable_nxt;

    // a fresh press with nothing gathered opens a new group
    gm1 = fresh ? held : gathered_r;
    ws1 = (fresh && gathered_r == '0) ? now_ms : window_start_r;
    gd1 = (fresh && gathered_r == '0) ? 1'b0 : group_done_r;
    window_age = now_ms - ws1;

    // first entry whose mask matches decides, even with an empty action
    found     = 1'b0;
    found_act = '0;
    for (int e = 0; e < STORED; e++) begin
      if (!found && entry_r[e][BTN_COUNT-1:0] == gm1) begin
        found     = 1'b1;
        found_act = entry_r[e][ENTRY_W-1 -: ACTION_W];
      end
    end

    gathered_nxt     = gm1;
    window_start_nxt = ws1;
    group_done_nxt   = gd1;
    recent_nxt       = recent_r;
    result.event_code = EV_NONE;

    if (gm1 != '0 && !gd1) begin
      if (window_age < {{(TIME_W-MS_CFG_W){1'b0}}, window_ms_r}) begin
        // window still open: follow the held mask
        gathered_nxt = held;
      end else begin
        // window expired: evaluate the gathered group once
        group_done_nxt = 1'b1;
        if (found_act != '0) begin
          recent_nxt = found_act;
          result.event_code = EV_CHORD;
        end else if (gm1[0]) begin
          result.event_code = EV_DOT;
        end else if (gm1[1]) begin
          result.event_code = EV_DASH;
        end else begin
          result.event_code = EV_SEND;
        end
      end
    end else if (held == '0 && gm1 != '0) begin
      // all released: re-arm
      gathered_nxt   = '0;
      group_done_nxt = 1'b0;
    end
    result.chord_action = recent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_seen_r     <= '0;
      stable_r       <= '0;
      gathered_r     <= '0;
      window_start_r <= '0;
      group_done_r   <= 1'b0;
      recent_r       <= '0;
      for (int i = 0; i < BTN_COUNT; i++) begin
        change_time_r[i] <= '0;
      end
    end else if (in_acc) begin
      raw_seen_r     <= raw_seen_nxt;
      stable_r       <= stable_nxt;
      gathered_r     <= gathered_nxt;
      window_start_r <= window_start_nxt;
      group_done_r   <= group_done_nxt;
      recent_r       <= recent_nxt;
      for (int i = 0; i < BTN_COUNT; i++) begin
        change_time_r[i] <= change_time_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: result register backed by a skid register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_data_r <= result;
      end else begin
        skid_data_r <= result;
      end
    end else if (out_take && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // skid entry is only ever filled behind a full result register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register valid while result register empty");

  // an evaluated group always has a nonzero gathered mask
  a_done_has_mask: assert property (@(posedge clk) disable iff (!rst_n)
    group_done_r |-> (gathered_r != '0))
    else $error("group marked done with empty gathered mask");

  // a chord event carries a nonempty action
  a_chord_action: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.event_code == EV_CHORD) |-> (out_data_r.chord_action != '0))
    else $error("chord event with empty action");

  // a sample taken into the skid entry means the result was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("stalled result lost a new sample");

endmodule
